>>> design/bdv_pkg.sv
// Shared types, constants and helpers for the binary 3x3 weighted vote filter.
// No dependencies; imported by every module of the block.
package bdv_pkg;

   // Line store geometry
   localparam int MAX_WIDTH   = 1024;
   localparam int COL_W       = $clog2(MAX_WIDTH);

   // Field and register widths
   localparam int PIX_W       = 8;
   localparam int FWIDTH_W    = 11;
   localparam int FHEIGHT_W   = 16;
   localparam int THR_W       = 5;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int SUM_W       = 5;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_VOTE_THRESHOLD = 2'd2;

   // Register reset values
   localparam logic [FWIDTH_W-1:0]  FRAME_WIDTH_RST    = 11'd640;
   localparam logic [FHEIGHT_W-1:0] FRAME_HEIGHT_RST   = 16'd480;
   localparam logic [THR_W-1:0]     VOTE_THRESHOLD_RST = 5'd8;

   // Request commands
   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_FLUSH = 1'b1;

   // Response pixel values
   localparam logic [PIX_W-1:0] PIX_FG = 8'hFF;
   localparam logic [PIX_W-1:0] PIX_BG = 8'h00;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Window bits outside the frame: top row, bottom row, left and right columns
   localparam logic [8:0] MASK_TOP    = 9'h007;
   localparam logic [8:0] MASK_BOTTOM = 9'h1C0;
   localparam logic [8:0] MASK_LEFT   = 9'h049;
   localparam logic [8:0] MASK_RIGHT  = 9'h124;
   localparam logic [8:0] WIN_KEEP    = 9'h0DB;

   // 1,2,1 / 2,4,2 / 1,2,1 kernel, bit r*3+c
   localparam logic [8:0][2:0] KERNEL_WEIGHT = {3'd1, 3'd2, 3'd1,
                                                3'd2, 3'd4, 3'd2,
                                                3'd1, 3'd2, 3'd1};

   // One classified request, handed from front to back
   typedef struct packed {
      logic [COL_W-1:0] col;        // line store column
      logic             fg;         // foreground bit
      logic             win_clr;    // first request of a new frame
      logic             emit;       // this request releases a response
      logic             row_first;  // response position on the top row
      logic             row_last;   // response position on the bottom row
      logic             col_first;  // response position on the left column
      logic             col_last;   // response position on the right column
   } bdv_item_type;

   // Weighted sum of the set window bits
   function automatic logic [SUM_W-1:0] vote_sum(input logic [8:0] bits);
      logic [SUM_W-1:0] acc;
      acc = '0;
      for (int k = 0; k < 9; k++) begin
         if (bits[k]) begin
            acc = acc + SUM_W'(KERNEL_WEIGHT[k]);
         end
      end
      return acc;
   endfunction

endpackage

>>> design/bdv_front.sv
// Front part: accepts requests, tracks input and response positions, classifies.
// Depends on bdv_pkg; feeds bdv_queue.
module bdv_front import bdv_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_command,
   input  logic [PIX_W-1:0]      req_in_pixel,
   input  logic [FWIDTH_W-1:0]   frame_width,
   input  logic [FHEIGHT_W-1:0]  frame_height,
   input  logic                  q_full,
   input  logic                  clr_busy,
   output logic                  push_valid,
   output bdv_item_type          push_item
);

   logic [COL_W-1:0]      in_col_ff, in_col_in;
   logic [FHEIGHT_W-1:0]  in_row_ff, in_row_in;
   logic [COL_W-1:0]      out_col_ff, out_col_in;
   logic [FHEIGHT_W-1:0]  out_row_ff, out_row_in;
   logic                  win_clr_ff, win_clr_in;

   logic [FWIDTH_W-1:0]   w_eff;
   logic [FHEIGHT_W-1:0]  h_eff;
   logic                  accept;
   logic                  in_col_end;
   logic                  emit;
   logic                  row_first, row_last, col_first, col_last;
   logic                  frame_end;

   // Clamp frame size to the supported range
   always_comb begin
      if (frame_width == '0) begin
         w_eff = FWIDTH_W'(1);
      end else if (frame_width > FWIDTH_W'(MAX_WIDTH)) begin
         w_eff = FWIDTH_W'(MAX_WIDTH);
      end else begin
         w_eff = frame_width;
      end
      h_eff = (frame_height == '0) ? FHEIGHT_W'(1) : frame_height;
   end

   assign req_ready = !q_full && !clr_busy;
   assign accept    = req_valid && req_ready;

   // Classify the request against the current positions
   assign in_col_end = ({1'b0, in_col_ff} + FWIDTH_W'(1)) >= w_eff;
   assign emit       = (in_row_ff >= FHEIGHT_W'(2))
                    || (in_row_ff == FHEIGHT_W'(1) && in_col_ff != '0);
   assign row_first  = out_row_ff == '0;
   assign row_last   = ({1'b0, out_row_ff} + (FHEIGHT_W+1)'(1)) >= {1'b0, h_eff};
   assign col_first  = out_col_ff == '0;
   assign col_last   = ({1'b0, out_col_ff} + FWIDTH_W'(1)) >= w_eff;
   assign frame_end  = emit && row_last && col_last;

   always_comb begin
      push_valid          = accept;
      push_item.col       = in_col_ff;
      push_item.fg        = (req_command == CMD_PIXEL) && (req_in_pixel != '0);
      push_item.win_clr   = win_clr_ff;
      push_item.emit      = emit;
      push_item.row_first = row_first;
      push_item.row_last  = row_last;
      push_item.col_first = col_first;
      push_item.col_last  = col_last;
   end

   // Advance positions; restart everything after the last response of a frame
   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      win_clr_in = win_clr_ff;
      if (accept) begin
         win_clr_in = 1'b0;
         if (in_col_end) begin
            in_col_in = '0;
            if (in_row_ff != '1) begin
               in_row_in = in_row_ff + FHEIGHT_W'(1);
            end
         end else begin
            in_col_in = in_col_ff + COL_W'(1);
         end
         if (frame_end) begin
            in_col_in  = '0;
            in_row_in  = '0;
            out_col_in = '0;
            out_row_in = '0;
            win_clr_in = 1'b1;
         end else if (emit) begin
            if (col_last) begin
               out_col_in = '0;
               out_row_in = out_row_ff + FHEIGHT_W'(1);
            end else begin
               out_col_in = out_col_ff + COL_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         win_clr_ff <= 1'b0;
      end else begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         win_clr_ff <= win_clr_in;
      end
   end

endmodule

>>> design/bdv_queue.sv
// Short request queue between front and back of the vote filter.
// Depends on bdv_pkg for the item type and depth.
module bdv_queue import bdv_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   input  bdv_item_type  push_item,
   output logic          full,
   output logic          pop_valid,
   input  logic          pop_ready,
   output bdv_item_type  pop_item
);

   bdv_item_type         slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]    count_ff, count_in;
   logic                 do_push, do_pop;

   assign full      = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_item  = slot_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop_valid && pop_ready;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed request
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> design/bdv_back.sv
// Back part: line store, 3x3 window, weighted vote and response register.
// Depends on bdv_pkg; takes classified requests from bdv_queue.
module bdv_back import bdv_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic [THR_W-1:0]  vote_threshold,
   input  logic              q_valid,
   input  bdv_item_type      q_item,
   output logic              q_ready,
   output logic              clr_busy,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [PIX_W-1:0]  rsp_out_pixel,
   output logic              rsp_frame_last
);

   // Line store entry: bit 0 older row, bit 1 newer row
   logic [1:0]           line_mem [MAX_WIDTH];
   logic [1:0]           rd_data_ff;
   logic                 fwd_ff, fwd_in;
   logic [1:0]           fwd_data_ff;

   logic                 clr_busy_ff, clr_busy_in;
   logic [COL_W-1:0]     clr_addr_ff, clr_addr_in;

   logic                 s1_valid_ff, s1_valid_in;
   bdv_item_type         s1_ff;
   logic [8:0]           window_ff, window_in;

   logic                 out_valid_ff, out_valid_in;
   logic [PIX_W-1:0]     out_pixel_ff;
   logic                 out_last_ff;

   logic                 s1_load, s1_adv;
   logic [1:0]           entry;
   logic [1:0]           wr_entry;
   logic [8:0]           win_base;
   logic [8:0]           keep;
   logic [SUM_W-1:0]     sum;
   logic                 mem_we;
   logic [COL_W-1:0]     mem_wa;
   logic [1:0]           mem_wd;

   assign clr_busy = clr_busy_ff;

   // Stage handshake: advance when no response is due or the slot is free
   assign s1_adv  = s1_valid_ff && (!s1_ff.emit || !out_valid_ff || rsp_ready);
   assign s1_load = q_valid && (!s1_valid_ff || s1_adv);
   assign q_ready = !s1_valid_ff || s1_adv;

   // Take the entry just written when the read collided with that write
   assign entry    = fwd_ff ? fwd_data_ff : rd_data_ff;
   assign wr_entry = {s1_ff.fg, entry[1]};
   assign fwd_in   = s1_adv && (q_item.col == s1_ff.col);

   // Shift the window left, insert the new column on the right
   always_comb begin
      win_base  = s1_ff.win_clr ? '0 : window_ff;
      window_in = ((win_base >> 1) & WIN_KEEP) | {s1_ff.fg, 2'b00, entry[1], 2'b00,
                                                   entry[0], 2'b00};
      keep = 9'h1FF;
      if (s1_ff.row_first) keep = keep & ~MASK_TOP;
      if (s1_ff.row_last)  keep = keep & ~MASK_BOTTOM;
      if (s1_ff.col_first) keep = keep & ~MASK_LEFT;
      if (s1_ff.col_last)  keep = keep & ~MASK_RIGHT;
      sum = vote_sum(window_in & keep);
   end

   // Clearing pass after reset, then request writes
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + COL_W'(1);
         if (clr_addr_ff == COL_W'(MAX_WIDTH - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
      mem_we = clr_busy_ff || s1_adv;
      mem_wa = clr_busy_ff ? clr_addr_ff : s1_ff.col;
      mem_wd = clr_busy_ff ? 2'b00 : wr_entry;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_mem[mem_wa] <= mem_wd;
      end
      if (s1_load) begin
         rd_data_ff <= line_mem[q_item.col];
      end
   end

   // Hold the entry being written, forwarded to the loaded request when flagged
   always_ff @(posedge clock) begin
      if (s1_load) begin
         fwd_data_ff <= wr_entry;
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (s1_load) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (s1_adv && s1_ff.emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         window_ff    <= '0;
         fwd_ff       <= 1'b0;
      end else begin
         clr_busy_ff  <= clr_busy_in;
         clr_addr_ff  <= clr_addr_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (s1_adv) begin
            window_ff <= window_in;
         end
         if (s1_load) begin
            fwd_ff <= fwd_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_ff <= q_item;
      end
      if (s1_adv && s1_ff.emit) begin
         out_pixel_ff <= ({1'b0, sum} >= {1'b0, vote_threshold}) ? PIX_FG : PIX_BG;
         out_last_ff  <= s1_ff.row_last && s1_ff.col_last;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_out_pixel  = out_pixel_ff;
   assign rsp_frame_last = out_last_ff;

endmodule

>>> design/binary_denoise_3x3_weighted_vote.sv
// Top level of the binary 3x3 weighted vote filter: registers and wiring.
// Depends on bdv_pkg, bdv_front, bdv_queue and bdv_back.
//
// Usage:
//  - Requests (req_*) carry one pixel in raster order, or a flush command that
//    counts as a background pixel. Each request releases at most one response.
//  - Responses (rsp_*) carry 255 or 0 per frame position; rsp_frame_last marks
//    the final position of the frame. Responses trail the requests by one row
//    plus one pixel, so one row plus one flush requests drain a frame.
//  - One request is accepted every cycle when the response side keeps up.
//    A request passes the queue, the line store read stage and the vote register
//    on its way to the response that it releases.
//  - When the receiver stalls, the response register holds, the back stage
//    stops, and the four-entry queue fills before req_ready drops.
//  - After reset the line store is cleared one entry a cycle, all 1024 entries,
//    with req_ready low; register writes are taken during that pass.
//  - Registers (csr_*) are to be written only while the block is idle; the block
//    does not enforce this. Frame size changes take effect for the next request.
module binary_denoise_3x3_weighted_vote import bdv_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_command,
   input  logic [PIX_W-1:0]       req_in_pixel,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [PIX_W-1:0]       rsp_out_pixel,
   output logic                   rsp_frame_last,
   input  logic                   csr_wr_en,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data
);

   logic [FWIDTH_W-1:0]   frame_width_ff, frame_width_in;
   logic [FHEIGHT_W-1:0]  frame_height_ff, frame_height_in;
   logic [THR_W-1:0]      vote_threshold_ff, vote_threshold_in;

   logic                  q_full;
   logic                  clr_busy;
   logic                  push_valid;
   bdv_item_type          push_item;
   logic                  pop_valid;
   logic                  pop_ready;
   bdv_item_type          pop_item;

   // Decode register writes; indexes beyond the list are dropped
   always_comb begin
      frame_width_in    = frame_width_ff;
      frame_height_in   = frame_height_ff;
      vote_threshold_in = vote_threshold_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            REG_FRAME_WIDTH:    frame_width_in    = csr_wr_data[FWIDTH_W-1:0];
            REG_FRAME_HEIGHT:   frame_height_in   = csr_wr_data[FHEIGHT_W-1:0];
            REG_VOTE_THRESHOLD: vote_threshold_in = csr_wr_data[THR_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff    <= FRAME_WIDTH_RST;
         frame_height_ff   <= FRAME_HEIGHT_RST;
         vote_threshold_ff <= VOTE_THRESHOLD_RST;
      end else begin
         frame_width_ff    <= frame_width_in;
         frame_height_ff   <= frame_height_in;
         vote_threshold_ff <= vote_threshold_in;
      end
   end

   bdv_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_command  (req_command),
      .req_in_pixel (req_in_pixel),
      .frame_width  (frame_width_ff),
      .frame_height (frame_height_ff),
      .q_full       (q_full),
      .clr_busy     (clr_busy),
      .push_valid   (push_valid),
      .push_item    (push_item)
   );

   bdv_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .full       (q_full),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   bdv_back u_back (
      .clock          (clock),
      .reset          (reset),
      .vote_threshold (vote_threshold_ff),
      .q_valid        (pop_valid),
      .q_item         (pop_item),
      .q_ready        (pop_ready),
      .clr_busy       (clr_busy),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_pixel  (rsp_out_pixel),
      .rsp_frame_last (rsp_frame_last)
   );

endmodule

>>> test/tb_binary_denoise_3x3_weighted_vote.sv
// Self-checking testbench for the binary 3x3 weighted vote filter.
// Depends on bdv_pkg and binary_denoise_3x3_weighted_vote; predicts every response locally.
module tb_binary_denoise_3x3_weighted_vote;
   import bdv_pkg::*;

   localparam int unsigned CYCLE_LIMIT   = 600000;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned RANDOM_ITEMS  = 440;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE = 2'd3;

   typedef struct packed {
      logic [PIX_W-1:0] pix;
      logic             last;
   } vote_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_command = CMD_PIXEL;
   logic [PIX_W-1:0]      req_in_pixel = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b1;
   logic [PIX_W-1:0]      rsp_out_pixel;
   logic                  rsp_frame_last;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wr_data = '0;

   // Local copy of the filter: registers, line stores, window and counters
   logic [FWIDTH_W-1:0]  fw  = FRAME_WIDTH_RST;
   logic [FHEIGHT_W-1:0] fh  = FRAME_HEIGHT_RST;
   logic [THR_W-1:0]     thr = VOTE_THRESHOLD_RST;
   logic                 row_older [MAX_WIDTH];
   logic                 row_newer [MAX_WIDTH];
   logic [8:0]           win = '0;
   int unsigned          in_col = 0;
   int unsigned          in_row = 0;
   int unsigned          out_col = 0;
   int unsigned          out_row = 0;

   vote_type    vote_q [$];
   bit          frame_done = 1'b0;
   bit          src_calm = 1'b0;
   bit          sink_calm = 1'b0;
   int unsigned sent_count = 0;
   int unsigned resp_count = 0;
   int unsigned frame_count = 0;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;

   binary_denoise_3x3_weighted_vote u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_command    (req_command),
      .req_in_pixel   (req_in_pixel),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_pixel  (rsp_out_pixel),
      .rsp_frame_last (rsp_frame_last),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses pending", cycle_count, vote_q.size());
         $display("[binary_denoise_3x3_weighted_vote] ERROR");
         $finish;
      end
   end

   function automatic int unsigned frame_cols();
      if (fw == 0) return 1;
      if (fw > MAX_WIDTH) return MAX_WIDTH;
      return fw;
   endfunction

   function automatic int unsigned frame_rows();
      return (fh == 0) ? 1 : fh;
   endfunction

   // Advance the local filter by one accepted request; queue the vote it releases
   function automatic void predict_vote(input logic cmd, input logic [PIX_W-1:0] pix);
      int unsigned w, h, col, sum;
      logic        fg, top, mid, ready, last;
      logic [8:0]  keep;
      vote_type    res;
      w   = frame_cols();
      h   = frame_rows();
      col = in_col;
      if (col >= MAX_WIDTH) col = 0;
      fg  = (cmd == CMD_PIXEL) && (pix != 0);
      top = row_older[col];
      mid = row_newer[col];
      row_older[col] = mid;
      row_newer[col] = fg;
      // shift the window left, new column enters on the right
      win = ((win >> 1) & WIN_KEEP) | {fg, 2'b00, mid, 2'b00, top, 2'b00};
      ready = (in_row >= 2) || (in_row == 1 && col >= 1);
      if (col + 1 >= w) begin
         in_col = 0;
         if (in_row < 65535) in_row++;
      end else begin
         in_col = col + 1;
      end
      if (!ready) return;
      // drop neighbours outside the frame
      keep = 9'h1FF;
      if (out_row == 0) keep &= ~MASK_TOP;
      if (out_row + 1 >= h) keep &= ~MASK_BOTTOM;
      if (out_col == 0) keep &= ~MASK_LEFT;
      if (out_col + 1 >= w) keep &= ~MASK_RIGHT;
      sum = 0;
      for (int k = 0; k < 9; k++) begin
         if (win[k] && keep[k]) sum += KERNEL_WEIGHT[k];
      end
      last     = (out_row + 1 >= h) && (out_col + 1 >= w);
      res.pix  = (sum >= thr) ? PIX_FG : PIX_BG;
      res.last = last;
      vote_q.push_back(res);
      if (last) begin
         win        = '0;
         in_col     = 0;
         in_row     = 0;
         out_col    = 0;
         out_row    = 0;
         frame_done = 1'b1;
         frame_count++;
      end else if (out_col + 1 >= w) begin
         out_col = 0;
         out_row++;
      end else begin
         out_col++;
      end
   endfunction

   task automatic report_mismatch(input string what, input logic [15:0] want,
                                  input logic [15:0] got);
      mismatch_count++;
      $display("mismatch on response %0d: %s, expected %0h got %0h",
               resp_count, what, want, got);
   endtask

   // Take responses, check each against the oldest prediction, stall at random
   initial begin : response_sink
      int unsigned stall_left;
      vote_type    want;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
            resp_count++;
            if (vote_q.size() == 0) begin
               report_mismatch("response with none pending", 16'h0, 16'(rsp_out_pixel));
            end else begin
               want = vote_q.pop_front();
               if (rsp_out_pixel !== want.pix) begin
                  report_mismatch("out_pixel", 16'(want.pix), 16'(rsp_out_pixel));
               end
               if (rsp_frame_last !== want.last) begin
                  report_mismatch("frame_last", 16'(want.last), 16'(rsp_frame_last));
               end
            end
            stall_left = sink_calm ? 0 : $urandom_range(0, 9);
            if (stall_left != 0) rsp_ready <= 1'b0;
         end else if (stall_left != 0) begin
            stall_left--;
            if (stall_left == 0) rsp_ready <= 1'b1;
         end
      end
   end

   // Send one request after a random gap; hold it until accepted
   task automatic send_request(input logic cmd, input logic [PIX_W-1:0] pix);
      int unsigned gap;
      gap = src_calm ? 0 : $urandom_range(0, 9);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_command  <= cmd;
      req_in_pixel <= pix;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_vote(cmd, pix);
      sent_count++;
   endtask

   // Drop valid, wait for all predicted responses, then let the pipeline settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (vote_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write all three registers back to back, optionally the unused index too
   task automatic write_regs(input logic [CSR_DATA_W-1:0] wdata,
                             input logic [CSR_DATA_W-1:0] hdata,
                             input logic [CSR_DATA_W-1:0] tdata, input bit with_spare);
      csr_wr_en <= 1'b1;
      if (with_spare) begin
         csr_index   <= REG_SPARE;
         csr_wr_data <= CSR_DATA_W'($urandom);
         @(posedge clock);
      end
      csr_index   <= REG_FRAME_WIDTH;
      csr_wr_data <= wdata;
      @(posedge clock);
      fw          = wdata[FWIDTH_W-1:0];
      csr_index   <= REG_FRAME_HEIGHT;
      csr_wr_data <= hdata;
      @(posedge clock);
      fh          = hdata[FHEIGHT_W-1:0];
      csr_index   <= REG_VOTE_THRESHOLD;
      csr_wr_data <= tdata;
      @(posedge clock);
      thr         = tdata[THR_W-1:0];
      csr_wr_en   <= 1'b0;
   endtask

   task automatic begin_frame(input logic [CSR_DATA_W-1:0] wdata,
                              input logic [CSR_DATA_W-1:0] hdata,
                              input logic [CSR_DATA_W-1:0] tdata, input bit with_spare);
      wait_idle();
      write_regs(wdata, hdata, tdata, with_spare);
      frame_done = 1'b0;
   endtask

   // Release pending responses: mostly flushes, some pixels past the frame
   task automatic drain_frame();
      while (!frame_done) begin
         if ($urandom_range(0, 3) == 0) send_request(CMD_PIXEL, PIX_W'($urandom_range(1, 255)));
         else send_request(CMD_FLUSH, PIX_W'($urandom));
      end
   endtask

   // One frame of random pixels, with stray flushes and an optional resize midway
   task automatic run_frame(input logic [CSR_DATA_W-1:0] wdata,
                            input logic [CSR_DATA_W-1:0] hdata,
                            input logic [CSR_DATA_W-1:0] tdata, input int unsigned density,
                            input bit cut);
      int unsigned n, cut_at;
      begin_frame(wdata, hdata, tdata, 1'b0);
      n      = frame_cols() * frame_rows();
      cut_at = cut ? $urandom_range(1, n) : n + 1;
      for (int unsigned i = 0; i < n; i++) begin
         if (i == cut_at) begin
            wait_idle();
            write_regs(CSR_DATA_W'($urandom_range(1, 8)), CSR_DATA_W'($urandom_range(1, 6)),
                       CSR_DATA_W'(thr), 1'b0);
         end
         if ($urandom_range(0, 99) < 8) begin
            send_request(CMD_FLUSH, PIX_W'($urandom));
         end else if ($urandom_range(0, 99) < density) begin
            send_request(CMD_PIXEL, PIX_W'($urandom_range(1, 255)));
         end else begin
            send_request(CMD_PIXEL, PIX_BG);
         end
      end
      drain_frame();
   endtask

   // 3x2 frame with pixel extremes and a flush inside the frame
   task automatic test_small_frame();
      begin_frame(16'd3, 16'd2, 16'd8, 1'b0);
      send_request(CMD_PIXEL, 8'hFF);
      send_request(CMD_PIXEL, 8'h00);
      send_request(CMD_PIXEL, 8'h01);
      send_request(CMD_FLUSH, 8'hFF);
      send_request(CMD_PIXEL, 8'h80);
      send_request(CMD_PIXEL, 8'h7F);
      send_request(CMD_PIXEL, 8'hFF);
      drain_frame();
   endtask

   // One-row frame; first flush releases nothing; zero threshold votes all foreground
   task automatic test_single_row();
      begin_frame(16'd2, 16'd1, 16'd0, 1'b0);
      send_request(CMD_PIXEL, 8'h00);
      send_request(CMD_PIXEL, 8'h00);
      drain_frame();
   endtask

   // Threshold above the largest possible sum: every vote is background
   task automatic test_threshold_above_max();
      begin_frame(16'd2, 16'd2, 16'd17, 1'b0);
      repeat (4) send_request(CMD_PIXEL, 8'hFF);
      drain_frame();
      begin_frame(16'd2, 16'd2, 16'hFFFF, 1'b0);
      repeat (4) send_request(CMD_PIXEL, 8'hFF);
      drain_frame();
   endtask

   // Zero width and height act as one; upper data bits are dropped
   task automatic test_size_aliases();
      begin_frame(16'hF800, 16'h0000, 16'hFFE4, 1'b1);
      send_request(CMD_PIXEL, 8'hFF);
      drain_frame();
   endtask

   // Start a frame of maximum height, then shrink it once the block is idle
   task automatic test_tall_frame_cut();
      begin_frame(16'd2, 16'hFFFF, 16'd6, 1'b0);
      repeat (6) send_request(CMD_PIXEL, $urandom_range(0, 1) ? 8'hFF : 8'h00);
      wait_idle();
      write_regs(16'd2, 16'd2, 16'd6, 1'b0);
      drain_frame();
   endtask

   // Width above the maximum acts as the full line store width, then shrink it
   task automatic test_wide_frames();
      begin_frame(16'h07FF, 16'd2, 16'd8, 1'b0);
      repeat (6) send_request(CMD_PIXEL, $urandom_range(0, 1) ? 8'hFF : 8'h00);
      wait_idle();
      write_regs(16'd4, 16'd2, 16'd8, 1'b0);
      drain_frame();
   endtask

   // Random frames of small sizes with random pressure on both sides
   task automatic test_random_frames();
      int unsigned start, pick, w, thr_pick;
      logic [CSR_DATA_W-1:0] wdata, hdata, tdata;
      start = sent_count;
      while (sent_count - start < RANDOM_ITEMS) begin
         src_calm  = ($urandom_range(0, 3) == 0);
         sink_calm = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 19);
         if (pick < 15) w = $urandom_range(1, 8);
         else if (pick < 19) w = $urandom_range(9, 40);
         else w = 0;
         wdata = {5'($urandom_range(0, 31)), 11'(w)};
         hdata = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 6));
         thr_pick = ($urandom_range(0, 4) != 0) ? $urandom_range(2, 12) : $urandom_range(0, 31);
         tdata = {11'($urandom_range(0, 2047)), 5'(thr_pick)};
         run_frame(wdata, hdata, tdata, $urandom_range(10, 90), $urandom_range(0, 6) == 0);
      end
   endtask

   initial begin
      for (int i = 0; i < MAX_WIDTH; i++) begin
         row_older[i] = 1'b0;
         row_newer[i] = 1'b0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_small_frame();
      test_single_row();
      test_threshold_above_max();
      test_size_aliases();
      test_tall_frame_cut();
      test_wide_frames();
      test_random_frames();
      wait_idle();
      $display("sent %0d requests, checked %0d responses over %0d frames in %0d cycles",
               sent_count, resp_count, frame_count, cycle_count);
      $display("covered size aliases, threshold extremes, mid-frame resize and random frames");
      if (mismatch_count == 0) begin
         $display("[binary_denoise_3x3_weighted_vote] OK");
      end else begin
         $display("[binary_denoise_3x3_weighted_vote] ERROR");
      end
      $finish;
   end

endmodule
